FILE: hw/rtl/apkc_pkg.sv
`timescale 1ns / 1ps

package apkc_pkg;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_CODE_FIRST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_SECOND = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_THIRD  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ANALOG_THR  = 2'd3;

  localparam logic [3:0] CODE_FIRST_RST  = 4'd1;
  localparam logic [3:0] CODE_SECOND_RST = 4'd5;
  localparam logic [3:0] CODE_THIRD_RST  = 4'd3;
  localparam logic [9:0] ANALOG_THR_RST  = 10'd580;

  // keypad command keys
  localparam logic [3:0] KEY_ON    = 4'd12;
  localparam logic [3:0] KEY_OFF   = 4'd13;
  localparam logic [3:0] KEY_TEST  = 4'd14;
  localparam logic [3:0] KEY_CLOCK = 4'd15;
  localparam logic [3:0] KEY_DIGIT_MAX = 4'd9;

  // sensor source codes
  localparam logic [3:0] SRC_NONE   = 4'd0;
  localparam logic [3:0] SRC_ANALOG = 4'd9;

  // clock reset value 16:33
  localparam logic [1:0] HOUR_TENS_RST   = 2'd1;
  localparam logic [3:0] HOUR_ONES_RST   = 4'd6;
  localparam logic [2:0] MINUTE_TENS_RST = 3'd3;
  localparam logic [3:0] MINUTE_ONES_RST = 4'd3;

  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  typedef enum logic [4:0] {
    ST_OFF        = 5'd0,
    ST_ARMED      = 5'd1,
    ST_ALARM      = 5'd2,
    ST_CODE_REL1  = 5'd3,
    ST_CODE_DIG1  = 5'd4,
    ST_CODE_REL2  = 5'd5,
    ST_CODE_DIG2  = 5'd6,
    ST_CODE_REL3  = 5'd7,
    ST_CODE_DIG3  = 5'd8,
    ST_CLK_REL1   = 5'd9,
    ST_CLK_HTENS  = 5'd10,
    ST_CLK_REL2   = 5'd11,
    ST_CLK_HONES  = 5'd12,
    ST_CLK_REL3   = 5'd13,
    ST_CLK_MTENS  = 5'd14,
    ST_CLK_REL4   = 5'd15,
    ST_CLK_MONES  = 5'd16
  } panel_state_t;

  typedef struct packed {
    logic [3:0] code_first;
    logic [3:0] code_second;
    logic [3:0] code_third;
    logic [9:0] analog_threshold;
  } cfg_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] sensor_bits;
    logic [9:0] adc_level;
    logic       key_valid;
    logic [3:0] key_code;
  } item_t;

  typedef struct packed {
    logic [4:0] panel_state;
    logic       alarm_active;
    logic [3:0] alarm_source;
    logic       siren_pulse;
    logic       test_active;
    logic       wrong_code;
    logic [1:0] hour_tens_out;
    logic [3:0] hour_ones_out;
    logic [2:0] minute_tens_out;
    logic [3:0] minute_ones_out;
  } result_t;

  // classified word between front and back
  typedef struct packed {
    logic       is_tick;
    logic [3:0] source;
    logic       key_hit;
    logic [3:0] key;
  } cmd_t;

endpackage

FILE: hw/rtl/apkc_chan_if.sv
`timescale 1ns / 1ps

interface apkc_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hw/rtl/apkc_front.sv
`timescale 1ns / 1ps

module apkc_front import apkc_pkg::*; (
  apkc_chan_if.sink  in_ch,
  input  cfg_t       cfg,
  input  logic       q_full,
  output logic       q_push,
  output cmd_t       q_cmd
);

  logic [3:0] digital_src;

  // lowest set bit wins
  always_comb begin
    digital_src = SRC_NONE;
    for (int i = 7; i >= 0; i--) begin
      if (in_ch.data.sensor_bits[i]) begin
        digital_src = 4'(i + 1);
      end
    end
  end

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;

  always_comb begin
    q_cmd.is_tick = in_ch.data.mode;
    q_cmd.key_hit = in_ch.data.key_valid;
    q_cmd.key     = in_ch.data.key_code;
    if (digital_src != SRC_NONE) begin
      q_cmd.source = digital_src;
    end else if (in_ch.data.adc_level < cfg.analog_threshold) begin
      q_cmd.source = SRC_ANALOG;
    end else begin
      q_cmd.source = SRC_NONE;
    end
  end

endmodule

FILE: hw/rtl/apkc_queue.sv
`timescale 1ns / 1ps

module apkc_queue import apkc_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t pop_cmd,
  output logic full,
  output logic empty
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST  = AW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  cmd_t          slot_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full    = (count_r == DEPTH_C);
  assign empty   = (count_r == '0);
  assign pop_cmd = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

FILE: hw/rtl/apkc_back.sv
`timescale 1ns / 1ps

module apkc_back import apkc_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  cfg_t          cfg,
  input  logic          q_empty,
  input  cmd_t          q_cmd,
  output logic          q_pop,
  apkc_chan_if.source   out_ch
);

  panel_state_t state_r, state_nxt;
  logic         alarm_r, alarm_nxt;
  logic         test_r, test_nxt;
  logic [3:0]   entered_r [2];
  logic [3:0]   entered_nxt [2];
  logic [1:0]   htens_r, htens_nxt;
  logic [3:0]   hones_r, hones_nxt;
  logic [2:0]   mtens_r, mtens_nxt;
  logic [3:0]   mones_r, mones_nxt;
  logic         out_valid_r;
  result_t      out_data_r, res_nxt;

  logic         no_key, is_digit, sense;
  logic [3:0]   source;
  logic         siren, wrong;
  logic [3:0]   mones_inc, hones_inc;
  logic [2:0]   mtens_inc;

  assign q_pop        = !q_empty && (!out_valid_r || out_ch.ready);
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  assign no_key   = !q_cmd.key_hit;
  assign is_digit = q_cmd.key_hit && (q_cmd.key <= KEY_DIGIT_MAX);

  assign mones_inc = mones_r + 4'd1;
  assign mtens_inc = mtens_r + 3'd1;
  assign hones_inc = hones_r + 4'd1;

  always_comb begin
    state_nxt      = state_r;
    alarm_nxt      = alarm_r;
    test_nxt       = test_r;
    entered_nxt[0] = entered_r[0];
    entered_nxt[1] = entered_r[1];
    htens_nxt      = htens_r;
    hones_nxt      = hones_r;
    mtens_nxt      = mtens_r;
    mones_nxt      = mones_r;
    source         = SRC_NONE;
    siren          = 1'b0;
    wrong          = 1'b0;
    sense          = 1'b0;

    if (q_cmd.is_tick) begin
      mones_nxt = mones_inc;
      if (mones_inc >= 4'd10) begin
        mones_nxt = '0;
        mtens_nxt = mtens_inc;
        if (mtens_inc >= 3'd6) begin
          mtens_nxt = '0;
          hones_nxt = hones_inc;
          if (hones_inc >= 4'd10 && htens_r < 2'd2) begin
            hones_nxt = '0;
            htens_nxt = htens_r + 2'd1;
          end else if (hones_inc >= 4'd4 && htens_r >= 2'd2) begin
            hones_nxt = '0;
            htens_nxt = '0;
          end
        end
      end
    end else begin
      sense = !alarm_r && (state_r != ST_OFF) && (5'(state_r) <= 5'(ST_CODE_DIG3));
      if (sense) begin
        source = q_cmd.source;
      end
      if (source != SRC_NONE) begin
        alarm_nxt = 1'b1;
      end
      siren = alarm_nxt && !test_r;

      unique case (state_r)
        ST_OFF: begin
          if (q_cmd.key_hit && q_cmd.key == KEY_ON) begin
            state_nxt = ST_ARMED;
          end else if (q_cmd.key_hit && q_cmd.key == KEY_TEST) begin
            state_nxt = ST_ARMED;
            test_nxt  = 1'b1;
          end else if (q_cmd.key_hit && q_cmd.key == KEY_CLOCK) begin
            state_nxt = ST_CLK_REL1;
          end
        end
        ST_ARMED, ST_ALARM: begin
          if (state_r == ST_ARMED && source != SRC_NONE) begin
            state_nxt = ST_ALARM;
          end else if (q_cmd.key_hit && q_cmd.key == KEY_OFF) begin
            // off goes through code entry unless in test mode
            if (!test_r) begin
              state_nxt = ST_CODE_REL1;
            end else begin
              state_nxt = ST_OFF;
              test_nxt  = 1'b0;
              alarm_nxt = 1'b0;
            end
          end
        end
        ST_CODE_REL1, ST_CODE_REL2, ST_CODE_REL3, ST_CLK_REL1,
        ST_CLK_REL2, ST_CLK_REL3, ST_CLK_REL4: begin
          if (no_key) begin
            state_nxt = panel_state_t'(5'(state_r) + 5'd1);
          end
        end
        ST_CODE_DIG1: begin
          if (is_digit) begin
            entered_nxt[0] = q_cmd.key;
            state_nxt      = ST_CODE_REL2;
          end
        end
        ST_CODE_DIG2: begin
          if (is_digit) begin
            entered_nxt[1] = q_cmd.key;
            state_nxt      = ST_CODE_REL3;
          end
        end
        ST_CODE_DIG3: begin
          if (is_digit) begin
            if (entered_r[0] == cfg.code_first && entered_r[1] == cfg.code_second &&
                q_cmd.key == cfg.code_third) begin
              state_nxt = ST_OFF;
              test_nxt  = 1'b0;
              alarm_nxt = 1'b0;
            end else begin
              wrong     = 1'b1;
              state_nxt = alarm_nxt ? ST_ALARM : ST_ARMED;
            end
          end
        end
        ST_CLK_HTENS: begin
          if (q_cmd.key_hit && q_cmd.key <= 4'd2) begin
            htens_nxt = q_cmd.key[1:0];
            state_nxt = ST_CLK_REL2;
          end
        end
        ST_CLK_HONES: begin
          if ((htens_r < 2'd2 && is_digit) ||
              (htens_r == 2'd2 && q_cmd.key_hit && q_cmd.key <= 4'd3)) begin
            hones_nxt = q_cmd.key;
            state_nxt = ST_CLK_REL3;
          end
        end
        ST_CLK_MTENS: begin
          if (q_cmd.key_hit && q_cmd.key <= 4'd5) begin
            mtens_nxt = q_cmd.key[2:0];
            state_nxt = ST_CLK_REL4;
          end
        end
        ST_CLK_MONES: begin
          if (is_digit) begin
            mones_nxt = q_cmd.key;
            state_nxt = ST_OFF;
          end
        end
        default: begin
        end
      endcase
    end

    res_nxt.panel_state     = 5'(state_nxt);
    res_nxt.alarm_active    = alarm_nxt;
    res_nxt.alarm_source    = source;
    res_nxt.siren_pulse     = siren;
    res_nxt.test_active     = test_nxt;
    res_nxt.wrong_code      = wrong;
    res_nxt.hour_tens_out   = htens_nxt;
    res_nxt.hour_ones_out   = hones_nxt;
    res_nxt.minute_tens_out = mtens_nxt;
    res_nxt.minute_ones_out = mones_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_OFF;
      alarm_r     <= 1'b0;
      test_r      <= 1'b0;
      htens_r     <= HOUR_TENS_RST;
      hones_r     <= HOUR_ONES_RST;
      mtens_r     <= MINUTE_TENS_RST;
      mones_r     <= MINUTE_ONES_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        state_r <= state_nxt;
        alarm_r <= alarm_nxt;
        test_r  <= test_nxt;
        htens_r <= htens_nxt;
        hones_r <= hones_nxt;
        mtens_r <= mtens_nxt;
        mones_r <= mones_nxt;
      end
      if (q_pop) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      entered_r[0] <= entered_nxt[0];
      entered_r[1] <= entered_nxt[1];
      out_data_r   <= res_nxt;
    end
  end

endmodule

FILE: hw/rtl/alarm_panel_keypad_controller.sv
`timescale 1ns / 1ps

// alarm panel controller: every accepted word on in_ch is either a sensor and keypad scan
// (mode 0) or a one-minute clock tick (mode 1), and gives exactly one result word on out_ch
// carrying the panel state, alarm and siren flags, the sensor found on that scan and the
// BCD 24-hour clock. a front stage classifies each word (priority sensor search against
// the analog threshold, key decode) and drops it into a queue (two entries by default); a
// back stage runs the 17-state panel machine and loads the result into an output register,
// after the queue slot. one word per clock is sustained while out_ch is ready;
// the output register and the queue let the input side keep accepting while a result waits.
// configuration (code digits, analog threshold) is written through cfg_we/cfg_index/
// cfg_wdata and should only change while no words are in flight.
module alarm_panel_keypad_controller import apkc_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  apkc_chan_if.sink             in_ch,
  apkc_chan_if.source           out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t cfg_r, cfg_nxt;

  // front to back queue
  logic q_push, q_pop, q_full, q_empty;
  cmd_t q_push_cmd, q_pop_cmd;

  // configuration registers, written one at a time
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_CODE_FIRST:  cfg_nxt.code_first       = cfg_wdata[3:0];
        CFG_CODE_SECOND: cfg_nxt.code_second      = cfg_wdata[3:0];
        CFG_CODE_THIRD:  cfg_nxt.code_third       = cfg_wdata[3:0];
        CFG_ANALOG_THR:  cfg_nxt.analog_threshold = cfg_wdata[9:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.code_first       <= CODE_FIRST_RST;
      cfg_r.code_second      <= CODE_SECOND_RST;
      cfg_r.code_third       <= CODE_THIRD_RST;
      cfg_r.analog_threshold <= ANALOG_THR_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // classify scans and ticks
  apkc_front u_front (
    .in_ch  (in_ch),
    .cfg    (cfg_r),
    .q_full (q_full),
    .q_push (q_push),
    .q_cmd  (q_push_cmd)
  );

  apkc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_push_cmd),
    .pop      (q_pop),
    .pop_cmd  (q_pop_cmd),
    .full     (q_full),
    .empty    (q_empty)
  );

  // panel state machine, clock and result register
  apkc_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_empty (q_empty),
    .q_cmd   (q_pop_cmd),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule
